// ===== design/pdr_pkg.sv =====
// Package with constants, types and tables for the planar dead-reckoning integrator.
package pdr_pkg;
	localparam int CordicSteps = 16;
	localparam logic signed [31:0] CordicStart = 32'sd652032874;
	localparam logic signed [19:0] PiQ16 = 20'sd205887;
	localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;

	typedef struct packed {
		logic [15:0] step_time;
		logic signed [15:0] yaw_rate;
		logic signed [15:0] body_accel_x;
		logic signed [15:0] body_accel_y;
		logic signed [15:0] heading;
	} pdr_in_t;

	typedef struct packed {
		logic signed [31:0] yaw_angle;
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic signed [47:0] position_x;
		logic signed [47:0] position_y;
	} pdr_out_t;

	typedef struct packed {
		logic start;
		logic done;
	} pdr_cordic_ctl_t;

	function automatic logic signed [19:0] atan_lut(input logic [3:0] i);
		logic signed [19:0] r;
		case (i)
			4'd0: r = 20'sd51472;
			4'd1: r = 20'sd30386;
			4'd2: r = 20'sd16055;
			4'd3: r = 20'sd8150;
			4'd4: r = 20'sd4091;
			4'd5: r = 20'sd2047;
			4'd6: r = 20'sd1024;
			4'd7: r = 20'sd512;
			4'd8: r = 20'sd256;
			4'd9: r = 20'sd128;
			4'd10: r = 20'sd64;
			4'd11: r = 20'sd32;
			4'd12: r = 20'sd16;
			4'd13: r = 20'sd8;
			4'd14: r = 20'sd4;
			default: r = 20'sd2;
		endcase
		return r;
	endfunction
endpackage

// ===== design/pdr_if.sv =====
// Valid/ready channel interface carrying one payload.
interface pdr_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/planar_dead_reckoning_integrator_unit.sv =====
// Top level of the planar dead-reckoning integrator with its shared multiplier sequencer.
//  channel | dir | fields
//  in_ch   | in  | step_time, yaw_rate, body_accel_x, body_accel_y, heading
//  out_ch  | out | yaw_angle, velocity_x, velocity_y, position_x, position_y
// A transfer accepted in the idle state starts the CORDIC, whose result is taken when it signals done.
// Nine products on one shared multiplier follow, each followed by an update step.
// Two more states, S_OUT and S_POS, update the state and load the result register, raising valid.
// The input is ready again after the result transfer, so no new item is taken before the last one is out.
// Reset clears all integrator state to zero.
// A stalled result holds in the output register and blocks the next transfer.
module planar_dead_reckoning_integrator_unit import pdr_pkg::*; (
	input logic clk,
	input logic arst_n,
	pdr_if.sink in_ch,
	pdr_if.source out_ch
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CORD = 7'b0000010,
		S_MUL = 7'b0000100,
		S_ACC = 7'b0001000,
		S_OUT = 7'b0010000,
		S_POS = 7'b0100000,
		S_WAIT = 7'b1000000
	} state_t;

	state_t st_q;
	pdr_in_t in_q;
	logic [3:0] k_q;
	logic signed [15:0] last_rate_q;
	logic signed [31:0] yaw_q, vx_q, vy_q, nvx_q, nvy_q, sin_q, cos_q;
	logic signed [16:0] lgx_q, lgy_q, gx_q, gy_q;
	logic signed [47:0] px_q, py_q;
	logic signed [63:0] prod_q, acc_q;
	logic signed [32:0] ma;
	logic signed [32:0] mb;
	logic signed [63:0] mp;
	pdr_cordic_ctl_t cc;
	logic signed [31:0] sn, cs;
	logic signed [16:0] t17;

	pdr_cordic u_cordic (.clk(clk), .arst_n(arst_n), .start(cc.start),
		.heading(in_ch.data.heading), .done(cc.done), .sin_out(sn), .cos_out(cs));

	assign cc.start = (st_q == S_IDLE) && in_ch.valid;
	assign in_ch.ready = (st_q == S_IDLE);
	assign t17 = {1'b0, in_q.step_time};

	function automatic logic signed [63:0] sat_rs(input logic signed [63:0] v,
			input int s, input int w);
		logic signed [63:0] r, hi;
		r = (v + (64'sd1 <<< (s - 1))) >>> s;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		if (r > hi) r = hi;
		else if (r < -hi - 64'sd1) r = -hi - 64'sd1;
		return r;
	endfunction

	function automatic logic signed [63:0] sat_w(input logic signed [63:0] v, input int w);
		logic signed [63:0] hi;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		if (v > hi) return hi;
		if (v < -hi - 64'sd1) return -hi - 64'sd1;
		return v;
	endfunction

	always_comb begin
		ma = '0;
		mb = '0;
		case (k_q)
			4'd0: begin ma = 33'(last_rate_q) + 33'(in_q.yaw_rate); mb = 33'(t17); end
			4'd1: begin ma = 33'(in_q.body_accel_x); mb = 33'(cos_q); end
			4'd2: begin ma = 33'(in_q.body_accel_y); mb = 33'(sin_q); end
			4'd3: begin ma = 33'(in_q.body_accel_x); mb = 33'(sin_q); end
			4'd4: begin ma = 33'(in_q.body_accel_y); mb = 33'(cos_q); end
			4'd5: begin ma = 33'(lgx_q) + 33'(gx_q); mb = 33'(t17); end
			4'd6: begin ma = 33'(lgy_q) + 33'(gy_q); mb = 33'(t17); end
			4'd7: begin ma = 33'(vx_q) + 33'(nvx_q); mb = 33'(t17); end
			default: begin ma = 33'(vy_q) + 33'(nvy_q); mb = 33'(t17); end
		endcase
		mp = ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			k_q <= '0;
			last_rate_q <= '0;
			yaw_q <= '0;
			vx_q <= '0;
			vy_q <= '0;
			lgx_q <= '0;
			lgy_q <= '0;
			px_q <= '0;
			py_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						in_q <= in_ch.data;
						st_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (cc.done) begin
						sin_q <= sn;
						cos_q <= cs;
						k_q <= '0;
						st_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q <= mp;
					st_q <= S_ACC;
				end
				S_ACC: begin
					st_q <= S_MUL;
					k_q <= k_q + 4'd1;
					case (k_q)
						4'd0: begin
							yaw_q <= 32'(sat_w(64'(yaw_q) + sat_rs(prod_q, 12, 63), 32));
							last_rate_q <= in_q.yaw_rate;
						end
						4'd1: acc_q <= prod_q;
						4'd2: gx_q <= 17'(sat_rs(acc_q - prod_q, 30, 17));
						4'd3: acc_q <= prod_q;
						4'd4: gy_q <= 17'(sat_rs(acc_q + prod_q, 30, 17));
						4'd5: nvx_q <= 32'(sat_w(64'(vx_q) + sat_rs(prod_q, 9, 63), 32));
						4'd6: nvy_q <= 32'(sat_w(64'(vy_q) + sat_rs(prod_q, 9, 63), 32));
						4'd7: px_q <= 48'(sat_w(64'(px_q) + sat_rs(prod_q, 17, 63), 48));
						default: begin
							py_q <= 48'(sat_w(64'(py_q) + sat_rs(prod_q, 17, 63), 48));
							st_q <= S_OUT;
						end
					endcase
				end
				S_OUT: begin
					vx_q <= nvx_q;
					vy_q <= nvy_q;
					lgx_q <= gx_q;
					lgy_q <= gy_q;
					st_q <= S_POS;
				end
				S_POS: begin
					out_ch.data <= '{yaw_q, vx_q, vy_q, px_q, py_q};
					out_ch.valid <= 1'b1;
					st_q <= S_WAIT;
				end
				S_WAIT: begin
					if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_ch.valid |-> st_q == S_WAIT)
		else $error("result valid outside wait state");
	assert property (@(posedge clk) disable iff (!arst_n) in_ch.ready |-> !out_ch.valid)
		else $error("input ready while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE && in_ch.valid) |=> st_q == S_CORD)
		else $error("accepted item not started");
endmodule

// ===== design/pdr_cordic.sv =====
// Iterative CORDIC producing sine and cosine of the heading.
module pdr_cordic import pdr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [15:0] heading,
	output logic done,
	output logic signed [31:0] sin_out,
	output logic signed [31:0] cos_out
);
	logic signed [31:0] x_q, y_q;
	logic signed [19:0] z_q;
	logic [3:0] i_q;
	logic busy_q, flip_q;
	logic signed [19:0] z0, zr;
	logic fl;
	logic signed [31:0] xs, ys;

	always_comb begin
		z0 = 20'(heading) <<< 3;
		zr = z0;
		fl = 1'b0;
		if (z0 > HalfPiQ16) begin
			zr = z0 - PiQ16;
			fl = 1'b1;
		end else if (z0 < -HalfPiQ16) begin
			zr = z0 + PiQ16;
			fl = 1'b1;
		end
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				x_q <= CordicStart;
				y_q <= '0;
				z_q <= zr;
				flip_q <= fl;
			end else if (busy_q) begin
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_lut(i_q);
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_lut(i_q);
				end
				i_q <= i_q + 4'd1;
				if (i_q == 4'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign sin_out = flip_q ? -y_q : y_q;
	assign cos_out = flip_q ? -x_q : x_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("cordic done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q && i_q == 4'd0)
		else $error("cordic did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(i_q) == 4'd15)
		else $error("cordic step count wrong");
endmodule

// ===== test/planar_dead_reckoning_integrator_unit_test.sv =====
// Testbench for the planar dead-reckoning integrator: directed table, random steps, own predictor.
module planar_dead_reckoning_integrator_unit_test;
	import pdr_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int RandomSteps = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fault_count = 0;
	int idle_cycles = 0;
	bit feed_done = 1'b0;
	bit hold_burst = 1'b0;

	pdr_if #(.T(pdr_in_t)) sample_ch ();
	pdr_if #(.T(pdr_out_t)) solution_ch ();

	planar_dead_reckoning_integrator_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(sample_ch),
		.out_ch(solution_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct {
		pdr_in_t sample;
		bit has_literal;
		pdr_out_t literal;
	} table_row_t;

	// Navigation state kept by the predictor.
	logic signed [15:0] prev_rate;
	logic signed [31:0] heading_sum;
	logic signed [16:0] prev_gx, prev_gy;
	logic signed [31:0] vel_x, vel_y;
	logic signed [47:0] pos_x, pos_y;

	pdr_out_t pending_solutions[$];
	table_row_t pending_rows[$];
	pdr_in_t feed_queue[$];
	table_row_t row_queue[$];
	table_row_t rows[$];

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_off(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic longint atan_angle(int i);
		longint angles[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return angles[i];
	endfunction

	task automatic rotation_terms(input longint hd, output longint sn, output longint cs);
		longint z, x, y, nx;
		bit flip;
		z = hd * 8;
		x = CordicStart;
		y = 0;
		flip = 1'b0;
		if (z > HalfPiQ16) begin
			z -= PiQ16;
			flip = 1'b1;
		end else if (z < -HalfPiQ16) begin
			z += PiQ16;
			flip = 1'b1;
		end
		for (int i = 0; i < CordicSteps; i++) begin
			if (z >= 0) begin
				nx = x - shr_floor(y, i);
				y = y + shr_floor(x, i);
				z -= atan_angle(i);
			end else begin
				nx = x + shr_floor(y, i);
				y = y - shr_floor(x, i);
				z += atan_angle(i);
			end
			x = nx;
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endtask

	task automatic clear_navigation();
		prev_rate = '0;
		heading_sum = '0;
		prev_gx = '0;
		prev_gy = '0;
		vel_x = '0;
		vel_y = '0;
		pos_x = '0;
		pos_y = '0;
	endtask

	task automatic predict_navigation(input pdr_in_t s, output pdr_out_t r);
		longint t, sn, cs, gx, gy, vx, vy, ax, ay;
		t = longint'(s.step_time);
		ax = s.body_accel_x;
		ay = s.body_accel_y;
		heading_sum = 32'(clamp(heading_sum +
			round_off((longint'(prev_rate) + s.yaw_rate) * t, 12), 32));
		prev_rate = s.yaw_rate;
		rotation_terms(longint'(s.heading), sn, cs);
		gx = clamp(round_off(ax * cs - ay * sn, 30), 17);
		gy = clamp(round_off(ax * sn + ay * cs, 30), 17);
		vx = clamp(vel_x + round_off((longint'(prev_gx) + gx) * t, 9), 32);
		vy = clamp(vel_y + round_off((longint'(prev_gy) + gy) * t, 9), 32);
		pos_x = 48'(clamp(pos_x + round_off((longint'(vel_x) + vx) * t, 17), 48));
		pos_y = 48'(clamp(pos_y + round_off((longint'(vel_y) + vy) * t, 17), 48));
		vel_x = 32'(vx);
		vel_y = 32'(vy);
		prev_gx = 17'(gx);
		prev_gy = 17'(gy);
		r.yaw_angle = heading_sum;
		r.velocity_x = vel_x;
		r.velocity_y = vel_y;
		r.position_x = pos_x;
		r.position_y = pos_y;
	endtask

	task automatic report_fault(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fault_count++;
	endtask

	function automatic int gap_length();
		if ($urandom_range(0, 3) == 0) begin
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(20, 80);
		end
		return $urandom_range(0, 3);
	endfunction

	function automatic pdr_in_t random_sample();
		pdr_in_t s;
		s.step_time = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
		s.yaw_rate = 16'($urandom);
		s.body_accel_x = 16'($urandom);
		s.body_accel_y = 16'($urandom);
		s.heading = 16'($urandom);
		return s;
	endfunction

	function automatic pdr_in_t make_sample(int t, int r, int ax, int ay, int hd);
		pdr_in_t s;
		s.step_time = 16'(t);
		s.yaw_rate = 16'(r);
		s.body_accel_x = 16'(ax);
		s.body_accel_y = 16'(ay);
		s.heading = 16'(hd);
		return s;
	endfunction

	task automatic add_row(input pdr_in_t s, input bit lit, input pdr_out_t v);
		table_row_t row;
		row.sample = s;
		row.has_literal = lit;
		row.literal = v;
		rows.push_back(row);
	endtask

	initial begin
		pdr_out_t zero_out;
		zero_out = '0;
		// A zero time step from reset leaves everything at zero.
		add_row(make_sample(0, 32767, 32767, -32768, 25736), 1'b1, zero_out);
		add_row(make_sample(0, -32768, -32768, 32767, -25736), 1'b0, zero_out);
		add_row(make_sample(65535, 32767, 32767, 32767, 0), 1'b0, zero_out);
		add_row(make_sample(65535, 32767, 32767, 32767, 25736), 1'b0, zero_out);
		add_row(make_sample(65535, 32767, -32768, 32767, 12868), 1'b0, zero_out);
		add_row(make_sample(65535, -32768, -32768, -32768, -25736), 1'b0, zero_out);
		add_row(make_sample(65535, -32768, 32767, -32768, -12868), 1'b0, zero_out);
		add_row(make_sample(1, 1, 256, 0, 12868), 1'b0, zero_out);
		add_row(make_sample(1, -1, 0, 256, 12869), 1'b0, zero_out);
		add_row(make_sample(100, 0, 256, 256, -12869), 1'b0, zero_out);
		add_row(make_sample(100, 0, 256, 256, 32767), 1'b0, zero_out);
		add_row(make_sample(100, 0, -256, 256, -32768), 1'b0, zero_out);
		add_row(make_sample(32768, 16384, 0, 0, 0), 1'b0, zero_out);
		add_row(make_sample(65535, 32767, 32767, 32767, 25736), 1'b0, zero_out);
		for (int i = 0; i < 8; i++) begin
			add_row(make_sample(65535, 32767, 32767, 0, 0), 1'b0, zero_out);
		end
		add_row(make_sample(65535, -32768, -32768, 0, 0), 1'b0, zero_out);
		add_row(make_sample(65535, -32768, -32768, 0, 0), 1'b0, zero_out);
	end

	initial begin
		sample_ch.valid <= 1'b0;
		sample_ch.data <= '0;
		solution_ch.ready <= 1'b0;
		clear_navigation();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) begin
			pdr_out_t want;
			table_row_t row;
			predict_navigation(sample_ch.data, want);
			pending_solutions.push_back(want);
			if (row_queue.size() > 0) begin
				row = row_queue.pop_front();
			end else begin
				row.has_literal = 1'b0;
			end
			pending_rows.push_back(row);
		end
		if (solution_ch.valid && solution_ch.ready) begin
			pdr_out_t got, want;
			table_row_t row;
			got = solution_ch.data;
			if (pending_solutions.size() == 0) begin
				report_fault("unexpected transfer", 0, 0);
			end else begin
				want = pending_solutions.pop_front();
				row = pending_rows.pop_front();
				if (got.yaw_angle !== want.yaw_angle)
					report_fault("yaw_angle", got.yaw_angle, want.yaw_angle);
				if (got.velocity_x !== want.velocity_x)
					report_fault("velocity_x", got.velocity_x, want.velocity_x);
				if (got.velocity_y !== want.velocity_y)
					report_fault("velocity_y", got.velocity_y, want.velocity_y);
				if (got.position_x !== want.position_x)
					report_fault("position_x", got.position_x, want.position_x);
				if (got.position_y !== want.position_y)
					report_fault("position_y", got.position_y, want.position_y);
				if (row.has_literal && got !== row.literal)
					report_fault("table row", got.yaw_angle, row.literal.yaw_angle);
			end
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		foreach (rows[i]) begin
			feed_queue.push_back(rows[i].sample);
			row_queue.push_back(rows[i]);
		end
		for (int i = 0; i < RandomSteps; i++) begin
			table_row_t row;
			row.sample = random_sample();
			row.has_literal = 1'b0;
			row.literal = '0;
			feed_queue.push_back(row.sample);
			row_queue.push_back(row);
		end
		while (feed_queue.size() > 0) begin
			sample_ch.data <= feed_queue[0];
			sample_ch.valid <= 1'b1;
			@(posedge clk);
			while (!sample_ch.ready) begin
				@(posedge clk);
			end
			void'(feed_queue.pop_front());
			gap = (feed_queue.size() > 0) ? gap_length() : 0;
			if (gap > 0 && !hold_burst) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		sample_ch.valid <= 1'b0;
		feed_done = 1'b1;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		repeat (200) begin
			solution_ch.ready <= 1'b1;
			@(posedge clk);
		end
		// Long hold-off while the sender keeps offering.
		hold_burst = 1'b1;
		solution_ch.ready <= 1'b0;
		repeat (400) @(posedge clk);
		hold_burst = 1'b0;
		forever begin
			stall = gap_length();
			if (stall > 0) begin
				solution_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			solution_ch.ready <= 1'b1;
			@(posedge clk);
			while (!solution_ch.valid) begin
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (solution_ch.valid && solution_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		fork
			begin
				wait (feed_done && pending_solutions.size() == 0);
				repeat (100) @(posedge clk);
				if (fault_count == 0 && pending_solutions.size() == 0) begin
					$display("planar_dead_reckoning_integrator_unit_test: clean");
				end else begin
					$display("planar_dead_reckoning_integrator_unit_test: errors");
				end
			end
			begin
				wait (idle_cycles >= WatchdogLimit);
				$display("timeout");
				$display("planar_dead_reckoning_integrator_unit_test: errors");
			end
		join_any
		$finish;
	end
endmodule
